FILE: design/h264_sps_header_parser_assert.svh
// Assertion helpers used by the parser back end.
`ifndef H264_SPS_HEADER_PARSER_ASSERT_SVH
`define H264_SPS_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define SPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

    localparam int MAX_PREFIX_ZEROS = 31;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    typedef logic [5:0] step_t;

    localparam step_t S_FIRST       = 6'd0;
    localparam step_t S_POC_TYPE    = 6'd2;
    localparam step_t S_POC_LSB     = 6'd3;
    localparam step_t S_POC_LOWER   = 6'd4;
    localparam step_t S_POC_CYC     = 6'd7;
    localparam step_t S_POC_OFS     = 6'd8;
    localparam step_t S_POC_NEXT    = 6'd9;
    localparam step_t S_WIDTH       = 6'd11;
    localparam step_t S_HEIGHT      = 6'd12;
    localparam step_t S_FRAME_MBS   = 6'd13;
    localparam step_t S_FIELD_ADAPT = 6'd14;
    localparam step_t S_DIRECT      = 6'd15;
    localparam step_t S_CROP_FLAG   = 6'd16;
    localparam step_t S_CROP_L      = 6'd17;
    localparam step_t S_CROP_R      = 6'd18;
    localparam step_t S_CROP_T      = 6'd19;
    localparam step_t S_CROP_B      = 6'd20;
    localparam step_t S_VUI         = 6'd21;
    localparam step_t S_AR_FLAG     = 6'd22;
    localparam step_t S_AR_IDC      = 6'd23;
    localparam step_t S_SAR_W       = 6'd24;
    localparam step_t S_OVS_FLAG    = 6'd26;
    localparam step_t S_OVS_APP     = 6'd27;
    localparam step_t S_VST_FLAG    = 6'd28;
    localparam step_t S_VFMT        = 6'd29;
    localparam step_t S_CDESC       = 6'd31;
    localparam step_t S_COLOR       = 6'd32;
    localparam step_t S_CLOC        = 6'd33;
    localparam step_t S_CLOC_T      = 6'd34;
    localparam step_t S_TIME        = 6'd36;
    localparam step_t S_UNITS       = 6'd37;
    localparam step_t S_SCALE       = 6'd38;
    localparam step_t S_FIXED       = 6'd39;
    localparam step_t S_DONE        = 6'd40;
    localparam step_t S_HALT        = 6'd41;

    localparam logic [7:0] EP_BYTE    = 8'h03;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] AR_EXTENDED = 8'd255;

    typedef enum logic [2:0] {
        KIND_DROP,
        KIND_HDR,
        KIND_PROFILE,
        KIND_LEVEL,
        KIND_DATA
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       fin;
    } entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BITS,
        BK_EMIT
    } back_state_t;

    // field width per syntax step, zero for ue(v)
    function automatic logic [5:0] step_width(input step_t s);
        logic [5:0] w;
        w = 6'd0;
        unique case (s)
            6'd4, 6'd10, 6'd13, 6'd14, 6'd15, 6'd16, 6'd21, 6'd22,
            6'd26, 6'd27, 6'd28, 6'd30, 6'd31, 6'd33, 6'd36, 6'd39: w = 6'd1;
            6'd29:        w = 6'd3;
            6'd23:        w = 6'd8;
            6'd24, 6'd25: w = 6'd16;
            6'd32:        w = 6'd24;
            6'd37, 6'd38: w = 6'd32;
            default:      w = 6'd0;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] sat16(input logic [32:0] v);
        return (v[32:16] != 17'd0) ? 16'hFFFF : v[15:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/sps_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface
`default_nettype wire

FILE: design/sps_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sps_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [15:0] width_mbs_minus_one;
    logic [15:0] height_units_minus_one;
    logic [15:0] crop_left;
    logic [15:0] crop_right;
    logic [15:0] crop_top;
    logic [15:0] crop_bottom;
    logic [31:0] units_in_tick;
    logic [31:0] timing_scale;
    logic        fixed_rate;
    logic        truncated;

    modport source (output valid, output profile, output level, output width_mbs_minus_one,
        output height_units_minus_one, output crop_left, output crop_right, output crop_top,
        output crop_bottom, output units_in_tick, output timing_scale, output fixed_rate,
        output truncated, input ready);
    modport sink (input valid, input profile, input level, input width_mbs_minus_one,
        input height_units_minus_one, input crop_left, input crop_right, input crop_top,
        input crop_bottom, input units_in_tick, input timing_scale, input fixed_rate,
        input truncated, output ready);
endinterface
`default_nettype wire

FILE: design/sps_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sps_front import sps_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    sps_in_if.sink    in_ch,
    input  wire logic q_full,
    output logic      q_push,
    output entry_t    q_entry
);
    logic [1:0] zrun_reg, zrun_next;
    logic [2:0] kcnt_reg, kcnt_next;
    logic       keep;

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;
    assign keep = !(zrun_reg == 2'd2 && in_ch.data_byte == EP_BYTE);

    always_comb
    begin
        zrun_next = zrun_reg;
        kcnt_next = kcnt_reg;
        q_entry.data = in_ch.data_byte;
        q_entry.fin  = in_ch.final_byte;
        q_entry.kind = KIND_DROP;
        if (keep)
        begin
            if (kcnt_reg[2])
            begin
                q_entry.kind = KIND_DATA;
            end
            else
            begin
                unique case (kcnt_reg[1:0])
                    2'd1:    q_entry.kind = KIND_PROFILE;
                    2'd3:    q_entry.kind = KIND_LEVEL;
                    default: q_entry.kind = KIND_HDR;
                endcase
                kcnt_next = kcnt_reg + 3'd1;
            end
        end
        if (in_ch.data_byte == ZERO_BYTE)
        begin
            zrun_next = (zrun_reg == 2'd2) ? 2'd2 : zrun_reg + 2'd1;
        end
        else
        begin
            zrun_next = 2'd0;
        end
        if (in_ch.final_byte)
        begin
            zrun_next = 2'd0;
            kcnt_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zrun_reg <= 2'd0;
            kcnt_reg <= 3'd0;
        end
        else if (q_push)
        begin
            zrun_reg <= zrun_next;
            kcnt_reg <= kcnt_next;
        end
    end
endmodule
`default_nettype wire

FILE: design/sps_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sps_queue import sps_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        not_empty,
    output entry_t      head
);
    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QPTR_W:0]     cnt_reg;

    assign full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/sps_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "h264_sps_header_parser_assert.svh"
module sps_back import sps_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  wire entry_t q_head,
    output logic        q_pop,
    sps_out_if.source   out_ch
);
    back_state_t st_reg, st_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;

    step_t       step_reg, step_next;
    logic [5:0]  pzc_reg, pzc_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  rem_reg, rem_next;
    logic        suffix_reg, suffix_next;
    logic [31:0] poc_reg, poc_next;
    logic [15:0] wid_reg, wid_next, hgt_reg, hgt_next;
    logic [15:0] cl_reg, cl_next, cr_reg, cr_next, ct_reg, ct_next, cb_reg, cb_next;
    logic [31:0] units_reg, units_next, scale_reg, scale_next;
    logic        fixed_reg, fixed_next;
    logic [7:0]  prof_reg, prof_next, lvl_reg, lvl_next;
    logic        ovalid_reg;

    logic        bit_en, b, emit_go, out_free, last_bit;
    logic        fin_req, go_req;
    logic [32:0] fin_val, base;
    logic [31:0] acc_sh;
    logic [5:0]  rem_dec;
    step_t       go_tgt;

    assign bit_en   = (st_reg == BK_BITS);
    assign b        = shift_reg[7];
    assign out_free = !ovalid_reg || out_ch.ready;
    assign last_bit = bit_en && (cnt_reg == 3'd7);
    assign emit_go  = (st_reg == BK_EMIT) && out_free;
    assign q_pop    = q_valid && ((st_reg == BK_IDLE) || (last_bit && !fin_reg));

    // sequencer
    always_comb
    begin
        st_next    = st_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        prof_next  = prof_reg;
        lvl_next   = lvl_reg;
        unique case (st_reg)
            BK_IDLE: st_next = BK_IDLE;
            BK_BITS:
            begin
                shift_next = {shift_reg[6:0], 1'b0};
                cnt_next   = cnt_reg + 3'd1;
                if (last_bit)
                begin
                    st_next = fin_reg ? BK_EMIT : BK_IDLE;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    st_next   = BK_IDLE;
                    prof_next = 8'd0;
                    lvl_next  = 8'd0;
                end
            end
            default: st_next = BK_IDLE;
        endcase
        if (q_pop)
        begin
            shift_next = q_head.data;
            cnt_next   = 3'd0;
            fin_next   = q_head.fin;
            if (q_head.kind == KIND_DATA)
            begin
                st_next = BK_BITS;
            end
            else
            begin
                if (q_head.kind == KIND_PROFILE)
                begin
                    prof_next = q_head.data;
                end
                if (q_head.kind == KIND_LEVEL)
                begin
                    lvl_next = q_head.data;
                end
                st_next = q_head.fin ? BK_EMIT : BK_IDLE;
            end
        end
    end

    // syntax walker, one bit per cycle while a data byte is in the bit state
    always_comb
    begin
        step_next   = step_reg;
        pzc_next    = pzc_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        suffix_next = suffix_reg;
        poc_next    = poc_reg;
        wid_next    = wid_reg;
        hgt_next    = hgt_reg;
        cl_next     = cl_reg;
        cr_next     = cr_reg;
        ct_next     = ct_reg;
        cb_next     = cb_reg;
        units_next  = units_reg;
        scale_next  = scale_reg;
        fixed_next  = fixed_reg;
        fin_req     = 1'b0;
        fin_val     = '0;
        go_req      = 1'b0;
        go_tgt      = step_reg;
        acc_sh      = {acc_reg[30:0], b};
        rem_dec     = (rem_reg != 6'd0) ? rem_reg - 6'd1 : 6'd0;
        base        = (33'd1 << pzc_reg) - 33'd1;

        if (bit_en && step_reg < S_DONE)
        begin
            if (step_width(step_reg) != 6'd0)
            begin
                acc_next = acc_sh;
                rem_next = rem_dec;
                if (rem_dec == 6'd0)
                begin
                    fin_req = 1'b1;
                    fin_val = {1'b0, acc_sh};
                end
            end
            else if (!suffix_reg)
            begin
                if (!b)
                begin
                    if (pzc_reg >= 6'(MAX_PREFIX_ZEROS))
                    begin
                        go_req = 1'b1;
                        go_tgt = S_HALT;
                    end
                    else
                    begin
                        pzc_next = pzc_reg + 6'd1;
                    end
                end
                else if (pzc_reg == 6'd0)
                begin
                    fin_req = 1'b1;
                end
                else
                begin
                    suffix_next = 1'b1;
                    rem_next    = pzc_reg;
                    acc_next    = '0;
                end
            end
            else
            begin
                acc_next = acc_sh;
                rem_next = rem_dec;
                if (rem_dec == 6'd0)
                begin
                    fin_req = 1'b1;
                    fin_val = base + {1'b0, acc_sh};
                end
            end
        end

        if (fin_req)
        begin
            go_req = 1'b1;
            go_tgt = step_reg + 6'd1;
            unique case (step_reg)
                S_POC_TYPE:
                begin
                    if (fin_val == 33'd0)
                        go_tgt = S_POC_LSB;
                    else if (fin_val == 33'd1)
                        go_tgt = S_POC_LOWER;
                    else
                        go_tgt = S_POC_NEXT;
                end
                S_POC_LSB:   go_tgt = S_POC_NEXT;
                S_POC_CYC:
                begin
                    poc_next = fin_val[31:0];
                    go_tgt   = (fin_val == 33'd0) ? S_POC_NEXT : S_POC_OFS;
                end
                S_POC_OFS:
                begin
                    poc_next = poc_reg - 32'd1;
                    go_tgt   = (poc_reg == 32'd1) ? S_POC_NEXT : S_POC_OFS;
                end
                S_WIDTH:     wid_next = sat16(fin_val);
                S_HEIGHT:    hgt_next = sat16(fin_val);
                S_FRAME_MBS: go_tgt = fin_val[0] ? S_DIRECT : S_FIELD_ADAPT;
                S_CROP_FLAG: go_tgt = fin_val[0] ? S_CROP_L : S_VUI;
                S_CROP_L:    cl_next = sat16(fin_val);
                S_CROP_R:    cr_next = sat16(fin_val);
                S_CROP_T:    ct_next = sat16(fin_val);
                S_CROP_B:    cb_next = sat16(fin_val);
                S_VUI:       go_tgt = fin_val[0] ? S_AR_FLAG : S_DONE;
                S_AR_FLAG:   go_tgt = fin_val[0] ? S_AR_IDC : S_OVS_FLAG;
                S_AR_IDC:
                    go_tgt = (fin_val == {25'd0, AR_EXTENDED}) ? S_SAR_W : S_OVS_FLAG;
                S_OVS_FLAG:  go_tgt = fin_val[0] ? S_OVS_APP : S_VST_FLAG;
                S_VST_FLAG:  go_tgt = fin_val[0] ? S_VFMT : S_CLOC;
                S_CDESC:     go_tgt = fin_val[0] ? S_COLOR : S_CLOC;
                S_CLOC:      go_tgt = fin_val[0] ? S_CLOC_T : S_TIME;
                S_TIME:      go_tgt = fin_val[0] ? S_UNITS : S_DONE;
                S_UNITS:     units_next = fin_val[31:0];
                S_SCALE:     scale_next = fin_val[31:0];
                S_FIXED:
                begin
                    fixed_next = fixed_reg | fin_val[0];
                    go_tgt     = S_DONE;
                end
                default:     go_tgt = step_reg + 6'd1;
            endcase
        end

        if (go_req)
        begin
            step_next   = go_tgt;
            acc_next    = '0;
            pzc_next    = '0;
            rem_next    = step_width(go_tgt);
            suffix_next = 1'b0;
        end

        if (emit_go)
        begin
            step_next   = S_FIRST;
            acc_next    = '0;
            pzc_next    = '0;
            rem_next    = step_width(S_FIRST);
            suffix_next = 1'b0;
            poc_next    = '0;
            wid_next    = '0;
            hgt_next    = '0;
            cl_next     = '0;
            cr_next     = '0;
            ct_next     = '0;
            cb_next     = '0;
            units_next  = '0;
            scale_next  = '0;
            fixed_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= BK_IDLE;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            step_reg   <= S_FIRST;
            pzc_reg    <= '0;
            acc_reg    <= '0;
            rem_reg    <= step_width(S_FIRST);
            suffix_reg <= 1'b0;
            poc_reg    <= '0;
            wid_reg    <= '0;
            hgt_reg    <= '0;
            cl_reg     <= '0;
            cr_reg     <= '0;
            ct_reg     <= '0;
            cb_reg     <= '0;
            units_reg  <= '0;
            scale_reg  <= '0;
            fixed_reg  <= 1'b0;
            prof_reg   <= '0;
            lvl_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            step_reg   <= step_next;
            pzc_reg    <= pzc_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            suffix_reg <= suffix_next;
            poc_reg    <= poc_next;
            wid_reg    <= wid_next;
            hgt_reg    <= hgt_next;
            cl_reg     <= cl_next;
            cr_reg     <= cr_next;
            ct_reg     <= ct_next;
            cb_reg     <= cb_next;
            units_reg  <= units_next;
            scale_reg  <= scale_next;
            fixed_reg  <= fixed_next;
            prof_reg   <= prof_next;
            lvl_reg    <= lvl_next;
            if (emit_go)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (emit_go)
        begin
            out_ch.profile                <= prof_reg;
            out_ch.level                  <= lvl_reg;
            out_ch.width_mbs_minus_one    <= wid_reg;
            out_ch.height_units_minus_one <= hgt_reg;
            out_ch.crop_left              <= cl_reg;
            out_ch.crop_right             <= cr_reg;
            out_ch.crop_top               <= ct_reg;
            out_ch.crop_bottom            <= cb_reg;
            out_ch.units_in_tick          <= units_reg;
            out_ch.timing_scale           <= scale_reg;
            out_ch.fixed_rate             <= fixed_reg;
            out_ch.truncated              <= (step_reg != S_DONE);
        end
    end

    assign out_ch.valid = ovalid_reg;

    `SPS_ASSERT_NEXT(a_bits_run, (st_reg == BK_BITS && cnt_reg != 3'd7), (st_reg == BK_BITS),
        "bit walk left early")
    `SPS_ASSERT_NEXT(a_emit_reset, emit_go, (step_reg == S_FIRST && ovalid_reg),
        "emit did not restart walker")
    `SPS_ASSERT_IMPL(a_rem_live, (step_reg < S_DONE && step_width(step_reg) != 6'd0),
        (rem_reg != 6'd0), "fixed field count hit zero")
endmodule
`default_nettype wire

FILE: design/h264_sps_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// SPS parser: raw NAL bytes in, one result per unit on the byte marked final.
// Header and dropped bytes are consumed by the back end without a bit walk;
// every later kept byte is walked one bit per cycle, and a byte that comes
// while the walker is idle is first loaded from the queue. The final byte
// leads to an emit state, held while the receiver holds off ready. A 4-entry
// queue decouples byte intake and emulation-prevention stripping from the
// bit walker.
module h264_sps_header_parser import sps_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    sps_in_if.sink    in_ch,
    sps_out_if.source out_ch
);
    logic   q_full, q_push, q_pop, q_valid;
    entry_t q_entry, q_head;

    sps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    sps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    sps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );
endmodule
`default_nettype wire

FILE: test/sps_tb_if.sv
`timescale 1ns / 1ps
package sps_tb_pkg;
    typedef struct packed {
        logic [7:0]  profile;
        logic [7:0]  level;
        logic [15:0] width_mbs_minus_one;
        logic [15:0] height_units_minus_one;
        logic [15:0] crop_left;
        logic [15:0] crop_right;
        logic [15:0] crop_top;
        logic [15:0] crop_bottom;
        logic [31:0] units_in_tick;
        logic [31:0] timing_scale;
        logic        fixed_rate;
        logic        truncated;
    } sps_info_t;
endpackage

FILE: test/sps_checker.sv
`timescale 1ns / 1ps
module sps_checker import sps_pkg::*; import sps_tb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    sps_in_if    in_ch,
    sps_out_if   out_ch,
    output int   fail_count,
    output int   pending
);
    sps_info_t info_q[$];

    logic [1:0]  zero_run;
    logic [2:0]  kept_cnt;
    step_t       step;
    logic [5:0]  pfx_zeros;
    logic [31:0] accum;
    logic [5:0]  bits_left;
    logic        in_suffix;
    logic [31:0] cyc_left;
    logic [15:0] dims[6];
    logic [31:0] units_r, scale_r;
    logic [7:0]  prof_r, lvl_r;
    logic        fixed_r;

    function automatic logic [5:0] width_of(step_t s);
        case (s)
            6'd4, 6'd10, 6'd13, 6'd14, 6'd15, 6'd16, 6'd21, 6'd22,
            6'd26, 6'd27, 6'd28, 6'd30, 6'd31, 6'd33, 6'd36, 6'd39: return 6'd1;
            6'd29: return 6'd3;
            6'd23: return 6'd8;
            6'd24, 6'd25: return 6'd16;
            6'd32: return 6'd24;
            6'd37, 6'd38: return 6'd32;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [15:0] clip16(logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic goto(step_t s);
        step = s;
        accum = '0;
        pfx_zeros = '0;
        bits_left = width_of(s);
        in_suffix = 1'b0;
    endtask

    task automatic clear_unit();
        zero_run = '0;
        kept_cnt = '0;
        cyc_left = '0;
        foreach (dims[i]) dims[i] = '0;
        units_r = '0;
        scale_r = '0;
        prof_r = '0;
        lvl_r = '0;
        fixed_r = 1'b0;
        goto(S_FIRST);
    endtask

    task automatic field_done(logic [63:0] v);
        case (step)
            S_POC_TYPE: goto(v == 0 ? S_POC_LSB : (v == 1 ? S_POC_LOWER : S_POC_NEXT));
            S_POC_LSB: goto(S_POC_NEXT);
            S_POC_CYC:
            begin
                cyc_left = v[31:0];
                goto(v[31:0] == 0 ? S_POC_NEXT : S_POC_OFS);
            end
            S_POC_OFS:
            begin
                cyc_left = cyc_left - 32'd1;
                goto(cyc_left == 0 ? S_POC_NEXT : S_POC_OFS);
            end
            S_WIDTH:
            begin
                dims[0] = clip16(v);
                goto(S_HEIGHT);
            end
            S_HEIGHT:
            begin
                dims[1] = clip16(v);
                goto(S_FRAME_MBS);
            end
            S_FRAME_MBS: goto(v != 0 ? S_DIRECT : S_FIELD_ADAPT);
            S_CROP_FLAG: goto(v != 0 ? S_CROP_L : S_VUI);
            S_CROP_L, S_CROP_R, S_CROP_T, S_CROP_B:
            begin
                dims[step - 6'd15] = clip16(v);
                goto(step + 6'd1);
            end
            S_VUI: goto(v != 0 ? S_AR_FLAG : S_DONE);
            S_AR_FLAG: goto(v != 0 ? S_AR_IDC : S_OVS_FLAG);
            S_AR_IDC: goto(v == AR_EXTENDED ? S_SAR_W : S_OVS_FLAG);
            S_OVS_FLAG: goto(v != 0 ? S_OVS_APP : S_VST_FLAG);
            S_VST_FLAG: goto(v != 0 ? S_VFMT : S_CLOC);
            S_CDESC: goto(v != 0 ? S_COLOR : S_CLOC);
            S_CLOC: goto(v != 0 ? S_CLOC_T : S_TIME);
            S_TIME: goto(v != 0 ? S_UNITS : S_DONE);
            S_UNITS:
            begin
                units_r = v[31:0];
                goto(S_SCALE);
            end
            S_SCALE:
            begin
                scale_r = v[31:0];
                goto(S_FIXED);
            end
            S_FIXED:
            begin
                if (v != 0) fixed_r = 1'b1;
                goto(S_DONE);
            end
            default: goto(step + 6'd1);
        endcase
    endtask

    task automatic walk_bit(logic b);
        logic [63:0] base;
        if (step >= S_DONE) return;
        if (width_of(step) != 0) begin
            accum = {accum[30:0], b};
            if (bits_left > 0) bits_left--;
            if (bits_left == 0) field_done({32'd0, accum});
            return;
        end
        if (!in_suffix) begin
            if (!b) begin
                if (pfx_zeros >= MAX_PREFIX_ZEROS) goto(S_HALT);
                else pfx_zeros++;
                return;
            end
            if (pfx_zeros == 0) begin
                field_done(64'd0);
                return;
            end
            in_suffix = 1'b1;
            bits_left = pfx_zeros;
            accum = '0;
            return;
        end
        accum = {accum[30:0], b};
        if (bits_left > 0) bits_left--;
        if (bits_left == 0) begin
            base = (64'd1 << pfx_zeros) - 64'd1;
            field_done(base + {32'd0, accum});
        end
    endtask

    task automatic take_byte(logic [7:0] d, logic fin);
        logic keep;
        sps_info_t r;
        keep = !(zero_run >= 2 && d == EP_BYTE);
        zero_run = (d == ZERO_BYTE) ? (zero_run >= 2 ? 2'd2 : zero_run + 2'd1) : 2'd0;
        if (keep) begin
            if (kept_cnt < 4) begin
                if (kept_cnt == 1) prof_r = d;
                if (kept_cnt == 3) lvl_r = d;
                kept_cnt++;
            end else begin
                for (int i = 7; i >= 0; i--) walk_bit(d[i]);
            end
        end
        if (fin) begin
            r.profile = prof_r;
            r.level = lvl_r;
            r.width_mbs_minus_one = dims[0];
            r.height_units_minus_one = dims[1];
            r.crop_left = dims[2];
            r.crop_right = dims[3];
            r.crop_top = dims[4];
            r.crop_bottom = dims[5];
            r.units_in_tick = units_r;
            r.timing_scale = scale_r;
            r.fixed_rate = fixed_r;
            r.truncated = (step != S_DONE);
            info_q.push_back(r);
            clear_unit();
        end
    endtask

    task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        clear_unit();
    end

    assign pending = info_q.size();

    always @(posedge clk)
    begin
        sps_info_t e;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (info_q.size() == 0) begin
                    $error("result with no expectation");
                    fail_count++;
                end else begin
                    e = info_q.pop_front();
                    cmp("profile", e.profile, out_ch.profile);
                    cmp("level", e.level, out_ch.level);
                    cmp("width_mbs_minus_one", e.width_mbs_minus_one,
                        out_ch.width_mbs_minus_one);
                    cmp("height_units_minus_one", e.height_units_minus_one,
                        out_ch.height_units_minus_one);
                    cmp("crop_left", e.crop_left, out_ch.crop_left);
                    cmp("crop_right", e.crop_right, out_ch.crop_right);
                    cmp("crop_top", e.crop_top, out_ch.crop_top);
                    cmp("crop_bottom", e.crop_bottom, out_ch.crop_bottom);
                    cmp("units_in_tick", e.units_in_tick, out_ch.units_in_tick);
                    cmp("timing_scale", e.timing_scale, out_ch.timing_scale);
                    cmp("fixed_rate", e.fixed_rate, out_ch.fixed_rate);
                    cmp("truncated", e.truncated, out_ch.truncated);
                end
            end
            if (in_ch.valid && in_ch.ready) take_byte(in_ch.data_byte, in_ch.final_byte);
        end
    end
endmodule

FILE: test/h264_sps_header_parser_tb.sv
`timescale 1ns / 1ps
module h264_sps_header_parser_tb;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1400;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   sent;
    int   cycles;
    bit   quiet;
    bit   done;

    sps_in_if  in_ch ();
    sps_out_if out_ch ();

    h264_sps_header_parser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sps_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // bit writer for well-formed units
    bit bits[$];

    function automatic void put_bits(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--) bits.push_back(v[i]);
    endfunction

    function automatic void put_ue(logic [31:0] v);
        logic [32:0] c;
        int n;
        c = {1'b0, v} + 33'd1;
        n = 0;
        while ((c >> (n + 1)) != 0) n++;
        for (int i = 0; i < n; i++) bits.push_back(1'b0);
        for (int i = n; i >= 0; i--) bits.push_back(c[i]);
    endfunction

    function automatic logic [31:0] rnd_ue();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(0, 3);
            2: return $urandom_range(0, 300);
            3: return $urandom_range(60000, 70000);
            4: return 32'hFFFFFFFE;
            default: return $urandom;
        endcase
    endfunction

    // stream of raw bytes for the next unit
    logic [7:0] unit_q[$];

    function automatic void build_sps();
        int poc;
        int cyc;
        bit vui;
        logic [7:0] b;
        int zr;
        bits.delete();
        put_ue(rnd_ue());
        put_ue(rnd_ue());
        poc = $urandom_range(0, 3);
        put_ue(poc);
        if (poc == 0) put_ue(rnd_ue());
        else if (poc == 1) begin
            put_bits($urandom, 1);
            put_ue(rnd_ue());
            put_ue(rnd_ue());
            cyc = $urandom_range(0, 4);
            put_ue(cyc);
            for (int i = 0; i < cyc; i++) put_ue(rnd_ue());
        end
        put_ue(rnd_ue());
        put_bits($urandom, 1);
        put_ue(rnd_ue());
        put_ue(rnd_ue());
        b = 8'($urandom_range(0, 1));
        put_bits({24'd0, b}, 1);
        if (b == 8'd0) put_bits($urandom, 1);
        put_bits($urandom, 1);
        b = 8'($urandom_range(0, 1));
        put_bits({24'd0, b}, 1);
        if (b != 8'd0) for (int i = 0; i < 4; i++) put_ue(rnd_ue());
        vui = $urandom_range(0, 3) != 0;
        put_bits({31'd0, vui}, 1);
        if (vui) begin
            b = 8'($urandom_range(0, 1));
            put_bits({24'd0, b}, 1);
            if (b != 8'd0) begin
                b = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'($urandom);
                put_bits({24'd0, b}, 8);
                if (b == 8'd255) put_bits($urandom, 32);
            end
            b = 8'($urandom_range(0, 1));
            put_bits({24'd0, b}, 1);
            if (b != 8'd0) put_bits($urandom, 1);
            b = 8'($urandom_range(0, 1));
            put_bits({24'd0, b}, 1);
            if (b != 8'd0) begin
                put_bits($urandom, 4);
                b = 8'($urandom_range(0, 1));
                put_bits({24'd0, b}, 1);
                if (b != 8'd0) put_bits($urandom, 24);
            end
            b = 8'($urandom_range(0, 1));
            put_bits({24'd0, b}, 1);
            if (b != 8'd0) begin
                put_ue(rnd_ue());
                put_ue(rnd_ue());
            end
            b = ($urandom_range(0, 3) != 0) ? 8'd1 : 8'd0;
            put_bits({24'd0, b}, 1);
            if (b != 8'd0) begin
                put_bits($urandom, 32);
                put_bits($urandom, 32);
                put_bits($urandom, 1);
            end
        end
        bits.push_back(1'b1);
        while (bits.size() % 8 != 0) bits.push_back(1'b0);
        unit_q.delete();
        unit_q.push_back(8'h67);
        unit_q.push_back(8'($urandom));
        unit_q.push_back(8'($urandom));
        unit_q.push_back(8'($urandom));
        // optionally cut short
        if ($urandom_range(0, 7) == 0 && bits.size() > 8)
            bits = bits[0:$urandom_range(0, bits.size() / 8 - 1) * 8 + 7];
        zr = 0;
        for (int i = 0; i < bits.size(); i += 8) begin
            b = {bits[i], bits[i+1], bits[i+2], bits[i+3],
                 bits[i+4], bits[i+5], bits[i+6], bits[i+7]};
            if (zr >= 2 && b <= 8'h03) begin
                unit_q.push_back(8'h03);
                zr = 0;
            end
            unit_q.push_back(b);
            zr = (b == 8'h00) ? zr + 1 : 0;
        end
        if ($urandom_range(0, 3) == 0) unit_q.push_back(8'h80);
    endfunction

    function automatic void build_noise();
        int n;
        n = $urandom_range(1, 12);
        unit_q.delete();
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 3))
                0: unit_q.push_back(8'h00);
                1: unit_q.push_back(8'h03);
                default: unit_q.push_back(8'($urandom));
            endcase
    endfunction

    // called at a falling edge; leaves valid high for the next call to reuse
    task automatic send_byte(logic [7:0] d, logic fin);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= d;
        in_ch.final_byte <= fin;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_unit();
        foreach (unit_q[i]) send_byte(unit_q[i], i == unit_q.size() - 1);
    endtask

    task automatic send_list(logic [7:0] l[$]);
        unit_q = l;
        send_unit();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver stalls
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        quiet = 1'b0;
        sent = 0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.final_byte = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: single final byte, short units, zero-run filtering
        send_list('{8'h67});
        send_list('{8'h03});
        send_list('{8'h00, 8'h00, 8'h03});
        send_list('{8'h67, 8'hFF, 8'h00, 8'hFF});
        send_list('{8'h00, 8'h00, 8'h03, 8'h03, 8'h00, 8'hFF});
        send_list('{8'h67, 8'h00, 8'h00, 8'h00, 8'h03, 8'hAA, 8'h55});
        // overlong prefix, then trailing junk
        send_list('{8'h67, 8'h42, 8'h00, 8'h1E, 8'h00, 8'h00, 8'h03, 8'h00,
                    8'h00, 8'h03, 8'h00, 8'hFF});
        // short unit of all-ones fields
        send_list('{8'h67, 8'h42, 8'h00, 8'h1E, 8'hFF, 8'hFF, 8'hFF});
        in_ch.valid <= 1'b0;

        // hold off until every expected result is back
        while (pending != 0) @(negedge clk);

        while (sent < ITEM_TARGET) begin
            if (sent > ITEM_TARGET - 150) quiet = 1'b1;
            if ($urandom_range(0, 4) == 0) build_noise();
            else build_sps();
            send_unit();
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
